[sv/irdg_pkg.sv]
`timescale 1ns / 1ps
package irdg_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int RADIX_WIDTH  = 5;
   localparam int DIGIT_WIDTH  = 4;
   localparam int CHAR_WIDTH   = 7;
   localparam int DIGIT_DEPTH  = 32;
   localparam int INDEX_WIDTH  = $clog2(DIGIT_DEPTH);
   localparam int COUNT_WIDTH  = $clog2(DIGIT_DEPTH + 1);
   // Quotient bits produced per divider cycle.
   localparam int SLICE_WIDTH  = 8;
   localparam int SLICE_STEPS  = VALUE_WIDTH / SLICE_WIDTH;
   localparam int STEP_WIDTH   = $clog2(SLICE_STEPS);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = RADIX_WIDTH'(16);
   localparam logic [CHAR_WIDTH-1:0]  NEWLINE_CHAR = CHAR_WIDTH'(10);

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [RADIX_WIDTH-1:0] base;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_EMIT
   } back_state_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] digit);
      logic [CHAR_WIDTH-1:0] result;
      begin
         case (digit)
            4'h0: result = CHAR_WIDTH'(8'h30);
            4'h1: result = CHAR_WIDTH'(8'h31);
            4'h2: result = CHAR_WIDTH'(8'h32);
            4'h3: result = CHAR_WIDTH'(8'h33);
            4'h4: result = CHAR_WIDTH'(8'h34);
            4'h5: result = CHAR_WIDTH'(8'h35);
            4'h6: result = CHAR_WIDTH'(8'h36);
            4'h7: result = CHAR_WIDTH'(8'h37);
            4'h8: result = CHAR_WIDTH'(8'h38);
            4'h9: result = CHAR_WIDTH'(8'h39);
            4'ha: result = CHAR_WIDTH'(8'h61);
            4'hb: result = CHAR_WIDTH'(8'h62);
            4'hc: result = CHAR_WIDTH'(8'h63);
            4'hd: result = CHAR_WIDTH'(8'h64);
            4'he: result = CHAR_WIDTH'(8'h65);
            4'hf: result = CHAR_WIDTH'(8'h66);
            default: result = CHAR_WIDTH'(8'h30);
         endcase
         return result;
      end
   endfunction

endpackage

[sv/irdg_req_if.sv]
`timescale 1ns / 1ps
interface irdg_req_if;
   logic                            valid;
   logic                            ready;
   logic [irdg_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

[sv/irdg_rsp_if.sv]
`timescale 1ns / 1ps
interface irdg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [irdg_pkg::CHAR_WIDTH-1:0] character;
   logic                           last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

[sv/irdg_queue.sv]
`timescale 1ns / 1ps
module irdg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  irdg_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output irdg_pkg::job_type pop_job
);
   import irdg_pkg::*;

   job_type                 slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0] fill_ff, fill_in;
   logic                    do_push, do_pop;

   assign push_ready = (fill_ff != QCOUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[sv/irdg_front.sv]
`timescale 1ns / 1ps
module irdg_front (
   input  logic                             clock,
   input  logic                             reset,
   irdg_req_if.sink                         req,
   input  logic                             csr_write_enable,
   input  logic [irdg_pkg::RADIX_WIDTH-1:0] csr_write_data,
   output logic                             push_valid,
   input  logic                             push_ready,
   output irdg_pkg::job_type                push_job
);
   import irdg_pkg::*;

   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [RADIX_WIDTH-1:0] base;

   always_comb begin
      radix_in = csr_write_enable ? csr_write_data : radix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Out-of-range bases saturate to the nearest supported one.
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = radix_ff;
      end
   end

   assign req.ready      = push_ready;
   assign push_valid     = req.valid;
   assign push_job.value = req.value;
   assign push_job.base  = base;

endmodule

[sv/irdg_back.sv]
`timescale 1ns / 1ps
module irdg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  irdg_pkg::job_type pop_job,
   irdg_rsp_if.source        rsp
);
   import irdg_pkg::*;

   back_state_type           state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   quo_ff, quo_in;
   logic [RADIX_WIDTH-1:0]   base_ff, base_in;
   logic [DIGIT_WIDTH-1:0]   rem_ff, rem_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   logic [CHAR_WIDTH-1:0]    out_char_ff, out_char_in;
   logic                     out_last_ff, out_last_in;
   logic [DIGIT_WIDTH-1:0]   store_ff [DIGIT_DEPTH];
   logic                     store_we;
   logic [DIGIT_WIDTH-1:0]   slice_rem;
   logic [SLICE_WIDTH-1:0]   slice_quo;
   logic [VALUE_WIDTH-1:0]   quo_next;
   logic [COUNT_WIDTH-1:0]   count_dec;
   logic                     out_free;

   // One slice of restoring division: SLICE_WIDTH quotient bits per cycle.
   always_comb begin
      logic [DIGIT_WIDTH:0] trial;
      logic [DIGIT_WIDTH-1:0] partial;
      partial = rem_ff;
      slice_quo = '0;
      for (int i = 0; i < SLICE_WIDTH; i++) begin
         trial = {partial, quo_ff[VALUE_WIDTH-1-i]};
         if (trial >= (DIGIT_WIDTH+1)'(base_ff)) begin
            trial = trial - (DIGIT_WIDTH+1)'(base_ff);
            slice_quo[SLICE_WIDTH-1-i] = 1'b1;
         end
         partial = trial[DIGIT_WIDTH-1:0];
      end
      slice_rem = partial;
   end

   assign quo_next  = {quo_ff[VALUE_WIDTH-SLICE_WIDTH-1:0], slice_quo};
   assign count_dec = count_ff - 1'b1;
   assign out_free  = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      base_in      = base_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      pop_ready    = 1'b0;
      store_we     = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               quo_in   = pop_job.value;
               base_in  = pop_job.base;
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               state_in = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            quo_in  = quo_next;
            rem_in  = slice_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(SLICE_STEPS - 1)) begin
               // The slice finished a digit; the remainder is that digit.
               store_we = 1'b1;
               count_in = count_ff + 1'b1;
               rem_in   = '0;
               step_in  = '0;
               if (quo_next == '0 || count_ff == COUNT_WIDTH'(DIGIT_DEPTH - 1)) begin
                  state_in = BACK_EMIT;
               end
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (count_ff == '0) begin
                  out_char_in = NEWLINE_CHAR;
                  out_last_in = 1'b1;
                  state_in    = BACK_IDLE;
               end else begin
                  out_char_in = digit_char(store_ff[count_dec[INDEX_WIDTH-1:0]]);
                  out_last_in = 1'b0;
                  count_in    = count_dec;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         quo_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         quo_ff       <= quo_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rem_ff      <= rem_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      if (store_we) begin
         store_ff[count_ff[INDEX_WIDTH-1:0]] <= slice_rem;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.character = out_char_ff;
   assign rsp.last      = out_last_ff;

endmodule

[sv/integer_to_radix_digits_core.sv]
`timescale 1ns / 1ps
// Converts each 32-bit unsigned value on the req channel into lower-case ASCII digits in the
// base held in the csr register (reset 10; 0 and 1 act as 2, 17 to 31 act as 16), sent on the
// rsp channel most significant digit first with no leading zeros, followed by a newline item
// with last set. A front stage latches the base with each value into a two-entry queue, so up
// to two values can wait while a back stage converts. The back stage divides by the base with
// a shared restoring divider that yields 8 quotient bits per cycle, digit after digit, and then
// sends one character per cycle while rsp is ready; it takes the next value from the queue only
// after it has issued the newline of the last one.
// Write the csr register only while no conversion is pending.
module integer_to_radix_digits_core (
   input  logic                             clock,
   input  logic                             reset,
   irdg_req_if.sink                         req,
   irdg_rsp_if.source                       rsp,
   input  logic                             csr_write_enable,
   input  logic [irdg_pkg::RADIX_WIDTH-1:0] csr_write_data
);
   import irdg_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   irdg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_job         (push_job)
   );

   irdg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   irdg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp       (rsp)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
   import irdg_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_COUNT = 12;
   localparam int ITEMS_PER_PHASE = 32;
   localparam int MAX_IDLE = 16;
   localparam logic [7:0] ZERO_CHAR = 8'h30;
   localparam logic [7:0] LETTER_A_CHAR = 8'h61;

   localparam logic [RADIX_WIDTH-1:0] RADIX_PLAN [9] = '{
      5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd3, 5'd7, 5'd10
   };

   localparam logic [VALUE_WIDTH-1:0] DIRECTED_VALUES [14] = '{
      32'd0, 32'd1, 32'd2, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100,
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h0000_FFFF, 32'd1_000_000_000
   };

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } char_item_type;

   class digit_string_tracker;
      logic [RADIX_WIDTH-1:0] radix_setting;
      char_item_type          pending_chars[$];
      int                     error_count;

      function new();
         radix_setting = RADIX_RESET;
         error_count = 0;
      endfunction

      // Expands one accepted value into its digit characters and the closing newline.
      function void predict_digits(input logic [VALUE_WIDTH-1:0] value);
         logic [DIGIT_WIDTH-1:0] digits [DIGIT_DEPTH];
         logic [VALUE_WIDTH-1:0] quotient;
         logic [VALUE_WIDTH-1:0] base;
         int                     count;
         char_item_type          item;
         if (radix_setting < RADIX_MIN) begin
            base = VALUE_WIDTH'(RADIX_MIN);
         end else if (radix_setting > RADIX_MAX) begin
            base = VALUE_WIDTH'(RADIX_MAX);
         end else begin
            base = VALUE_WIDTH'(radix_setting);
         end
         quotient = value;
         count = 0;
         // Digits come out least significant first and are sent in reverse.
         do begin
            digits[count] = DIGIT_WIDTH'(quotient % base);
            count++;
            quotient = quotient / base;
         end while (quotient != 0 && count < DIGIT_DEPTH);
         for (int i = count - 1; i >= 0; i--) begin
            if (digits[i] < 10) begin
               item.character = CHAR_WIDTH'(ZERO_CHAR + digits[i]);
            end else begin
               item.character = CHAR_WIDTH'(LETTER_A_CHAR + digits[i] - 10);
            end
            item.last = 1'b0;
            pending_chars.push_back(item);
         end
         item.character = NEWLINE_CHAR;
         item.last = 1'b1;
         pending_chars.push_back(item);
      endfunction

      function void check_char(input logic [CHAR_WIDTH-1:0] character, input logic last);
         char_item_type expected;
         if (pending_chars.size() == 0) begin
            $error("unexpected item: character %h, last %b", character, last);
            error_count++;
         end else begin
            expected = pending_chars.pop_front();
            if (character !== expected.character) begin
               $error("character: expected %h, actual %h", expected.character, character);
               error_count++;
            end
            if (last !== expected.last) begin
               $error("last: expected %b, actual %b", expected.last, last);
               error_count++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [RADIX_WIDTH-1:0] csr_write_data;
   logic                   idle_on;
   int                     cycle_count = 0;
   digit_string_tracker    tracker;

   irdg_req_if req_bus ();
   irdg_rsp_if rsp_bus ();

   integer_to_radix_digits_core DUT (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Each call starts right after a rising edge; valid is left high after the handshake
   // so that a back-to-back item keeps it high without a drop.
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.predict_digits(value);
   endtask

   task automatic receive_chars();
      int stall;
      forever begin
         stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         tracker.check_char(rsp_bus.character, rsp_bus.last);
      end
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (tracker.pending_chars.size() != 0) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_WIDTH-1:0] radix);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= radix;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.radix_setting = radix;
   endtask

   // Mixes extremes, short values and full-width values so that every digit count shows up.
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      logic [VALUE_WIDTH-1:0] value;
      case ($urandom_range(0, 9))
         0: value = '0;
         1: value = '1;
         2: value = $urandom_range(0, 40);
         3, 4, 5: value = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   initial begin
      tracker = new();
      reset = 1'b1;
      idle_on = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_chars();
      join_none

      // The directed values run at the reset base of ten.
      foreach (DIRECTED_VALUES[i]) send_value(DIRECTED_VALUES[i]);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 9) begin
            write_radix(RADIX_PLAN[phase]);
         end else begin
            write_radix(RADIX_WIDTH'($urandom_range(0, 31)));
         end
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (ITEMS_PER_PHASE) send_value(pick_value());
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.error_count == 0 && tracker.pending_chars.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
